### sv/hdrcls_pkg.sv
// types and constants shared by the header classifier
package hdrcls_pkg;

    localparam int DEF_COUNT_WIDTH      = 32;
    localparam int DEF_BYTE_COUNT_WIDTH = 48;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_TCP   = 2'd1,
        KIND_UDP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ETH_OTHER = 2'd0,
        ETH_IPV4  = 2'd1,
        ETH_IPV6  = 2'd2
    } ether_t;

    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] ETYPE_IPV6_HI = 8'h86;
    localparam logic [7:0] ETYPE_IPV6_LO = 8'hDD;

    localparam logic [6:0] ETH_HDR_BYTES  = 7'd14;
    localparam logic [5:0] IPV6_HDR_BYTES = 6'd40;
    localparam logic [5:0] UDP_HDR_BYTES  = 6'd8;

    // byte positions within the frame
    localparam logic [15:0] POS_TYPE_HI   = 16'd12;
    localparam logic [15:0] POS_TYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IP_START  = 16'd14;
    localparam logic [15:0] POS_V4_LEN_HI = 16'd16;
    localparam logic [15:0] POS_V4_LEN_LO = 16'd17;
    localparam logic [15:0] POS_V4_PROTO  = 16'd23;
    localparam logic [15:0] POS_V6_LEN_HI = 16'd18;
    localparam logic [15:0] POS_V6_LEN_LO = 16'd19;
    localparam logic [15:0] POS_V6_NEXT   = 16'd20;
    localparam logic [15:0] POS_SAT       = 16'hFFFF;

    // byte offsets within the transport header
    localparam logic [15:0] OFF_SRC_HI   = 16'd0;
    localparam logic [15:0] OFF_SRC_LO   = 16'd1;
    localparam logic [15:0] OFF_DST_HI   = 16'd2;
    localparam logic [15:0] OFF_DST_LO   = 16'd3;
    localparam logic [15:0] OFF_LEN_HI   = 16'd4;
    localparam logic [15:0] OFF_LEN_LO   = 16'd5;
    localparam logic [15:0] OFF_TCP_DOFF = 16'd12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [5:0]   l4_header_len;
        logic [15:0]  payload_len;
        logic         matched;
        logic [31:0]  frame_count;
        logic [31:0]  tcp_count;
        logic [31:0]  udp_count;
        logic [31:0]  tcp_matched;
        logic [31:0]  udp_matched;
        logic [47:0]  class_bytes;
    } out_t;

    // header fields of a finished frame
    typedef struct packed {
        ether_t       ether_class;
        logic [7:0]   l4_protocol;
        logic [15:0]  ip_length;
        logic [5:0]   ip_header_bytes;
        logic [6:0]   transport_start;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [15:0]  l4_len;
        logic [15:0]  last_pos;
    } fin_t;

    // classified frame before the counter update
    typedef struct packed {
        kind_t        kind;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [5:0]   l4_header_len;
        logic [15:0]  payload_len;
        logic         matched;
        logic [16:0]  byte_inc;
    } res_t;

endpackage

### sv/l2_l4_header_classifier_core.sv
// ethernet/ipv4/ipv6 tcp/udp header classifier with filter and running counters
//
// usage
//   s_ channel: one frame byte per transfer, starting at the destination
//   address; frame_end marks the last byte; one per cycle if s_ready is high.
//   m_ channel: one result per frame, issued for the transfer with frame_end
//   set: kind, ports, transport header length, payload length, filter match
//   and the running packet and byte counters after this frame.
//   cfg_wr_en/cfg_wr_data: writes filter_reg, zero matches all tcp/udp packets.
// throughput and result timing
//   one byte per cycle while s_ready is high. m_valid rises once the last
//   byte has passed the capture, classify and counter update registers.
// reset
//   aresetn low clears the per-frame header state, counters, filter and all
//   valid flags.
// stall
//   a result held by m_ready low keeps its value; two more finished frames
//   can queue in the classify stages before s_ready drops.
module l2_l4_header_classifier_core #(
    parameter int COUNT_WIDTH      = hdrcls_pkg::DEF_COUNT_WIDTH,
    parameter int BYTE_COUNT_WIDTH = hdrcls_pkg::DEF_BYTE_COUNT_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hdrcls_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hdrcls_pkg::out_t  m_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);
    import hdrcls_pkg::*;

    // per-frame header state
    logic [15:0] pos_reg, pos_next;
    ether_t      class_reg, class_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] iplen_reg, iplen_next;
    logic [6:0]  ts_reg, ts_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] l4len_reg, l4len_next;
    logic [7:0]  type_hi_reg, type_hi_next;

    // header state after the current byte
    ether_t      upd_class;
    logic [5:0]  upd_ihb;
    logic [7:0]  upd_proto;
    logic [15:0] upd_iplen;
    logic [6:0]  upd_ts;
    logic [15:0] upd_sport;
    logic [15:0] upd_dport;
    logic [15:0] upd_l4len;
    logic [7:0]  upd_type_hi;
    logic [15:0] t_pos;
    logic [15:0] t_off;
    logic        t_ge;
    logic        in_l4;

    logic [15:0] filter_reg;

    logic        fin_valid_reg, fin_valid_next;
    fin_t        fin_reg;
    logic        res_valid_reg, res_valid_next;
    res_t        res_reg;
    res_t        res_calc;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg;

    logic [COUNT_WIDTH-1:0]      tot_cnt_reg, tcp_cnt_reg, udp_cnt_reg;
    logic [COUNT_WIDTH-1:0]      tcpm_cnt_reg, udpm_cnt_reg;
    logic [BYTE_COUNT_WIDTH-1:0] tcp_octets_reg, udp_octets_reg;

    logic s_xfer;
    logic out_free;
    logic res_adv;
    logic res_free;
    logic fin_adv;
    logic fin_free;

    // classify stage signals
    logic        tcp_ok;
    logic        udp_ok;
    logic [5:0]  ihb_eff;
    logic [17:0] v_tcp;
    logic [17:0] v_udp;
    logic [17:0] v_sel;
    logic [15:0] pl_clamp;

    // handshake
    assign out_free = !out_valid_reg || m_ready;
    assign res_adv  = res_valid_reg && out_free;
    assign res_free = !res_valid_reg || res_adv;
    assign fin_adv  = fin_valid_reg && res_free;
    assign fin_free = !fin_valid_reg || fin_adv;
    assign s_ready  = fin_free;
    assign s_xfer   = s_valid && fin_free;

    assign fin_valid_next = (fin_valid_reg && !fin_adv) || (s_xfer && s_data.frame_end);
    assign res_valid_next = (res_valid_reg && !res_adv) || fin_adv;
    assign out_valid_next = (out_valid_reg && !m_ready) || res_adv;

    // byte capture
    assign t_pos = {9'd0, upd_ts};
    assign t_ge  = pos_reg >= t_pos;
    assign t_off = pos_reg - t_pos;
    assign in_l4 = (upd_class != ETH_OTHER) && (pos_reg >= POS_IP_START) && t_ge
                   && (pos_reg != POS_SAT);

    always_comb begin
        upd_class   = class_reg;
        upd_ihb     = ihb_reg;
        upd_proto   = proto_reg;
        upd_iplen   = iplen_reg;
        upd_ts      = ts_reg;
        upd_type_hi = type_hi_reg;
        if (pos_reg != POS_SAT) begin
            if (pos_reg == POS_TYPE_HI) begin
                upd_type_hi = s_data.data_byte;
            end else if (pos_reg == POS_TYPE_LO) begin
                if (type_hi_reg == ETYPE_IPV4_HI && s_data.data_byte == ETYPE_IPV4_LO) begin
                    upd_class = ETH_IPV4;
                end else if (type_hi_reg == ETYPE_IPV6_HI
                             && s_data.data_byte == ETYPE_IPV6_LO) begin
                    upd_class = ETH_IPV6;
                    upd_ihb   = IPV6_HDR_BYTES;
                    upd_ts    = ETH_HDR_BYTES + {1'b0, IPV6_HDR_BYTES};
                end else begin
                    upd_class = ETH_OTHER;
                end
            end
            if (upd_class == ETH_IPV4) begin
                if (pos_reg == POS_IP_START) begin
                    upd_ihb = {s_data.data_byte[3:0], 2'b00};
                    upd_ts  = ETH_HDR_BYTES + {1'b0, s_data.data_byte[3:0], 2'b00};
                end
                if (pos_reg == POS_V4_LEN_HI) upd_iplen[15:8] = s_data.data_byte;
                if (pos_reg == POS_V4_LEN_LO) upd_iplen[7:0] = s_data.data_byte;
                if (pos_reg == POS_V4_PROTO) upd_proto = s_data.data_byte;
            end else if (upd_class == ETH_IPV6) begin
                if (pos_reg == POS_V6_LEN_HI) upd_iplen[15:8] = s_data.data_byte;
                if (pos_reg == POS_V6_LEN_LO) upd_iplen[7:0] = s_data.data_byte;
                if (pos_reg == POS_V6_NEXT) upd_proto = s_data.data_byte;
            end
        end
    end

    always_comb begin
        upd_sport = sport_reg;
        upd_dport = dport_reg;
        upd_l4len = l4len_reg;
        if (in_l4) begin
            if (t_off == OFF_SRC_HI) upd_sport[15:8] = s_data.data_byte;
            if (t_off == OFF_SRC_LO) upd_sport[7:0] = s_data.data_byte;
            if (t_off == OFF_DST_HI) upd_dport[15:8] = s_data.data_byte;
            if (t_off == OFF_DST_LO) upd_dport[7:0] = s_data.data_byte;
            if (t_off == OFF_LEN_HI) upd_l4len[15:8] = s_data.data_byte;
            if (t_off == OFF_LEN_LO) upd_l4len[7:0] = s_data.data_byte;
            if (t_off == OFF_TCP_DOFF && upd_proto == PROTO_TCP) begin
                upd_l4len = {10'd0, s_data.data_byte[7:4], 2'b00};
            end
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        class_next   = class_reg;
        ihb_next     = ihb_reg;
        proto_next   = proto_reg;
        iplen_next   = iplen_reg;
        ts_next      = ts_reg;
        sport_next   = sport_reg;
        dport_next   = dport_reg;
        l4len_next   = l4len_reg;
        type_hi_next = type_hi_reg;
        if (s_xfer) begin
            if (s_data.frame_end) begin
                pos_next     = '0;
                class_next   = ETH_OTHER;
                ihb_next     = '0;
                proto_next   = '0;
                iplen_next   = '0;
                ts_next      = '0;
                sport_next   = '0;
                dport_next   = '0;
                l4len_next   = '0;
                type_hi_next = '0;
            end else begin
                pos_next     = (pos_reg == POS_SAT) ? pos_reg : pos_reg + 16'd1;
                class_next   = upd_class;
                ihb_next     = upd_ihb;
                proto_next   = upd_proto;
                iplen_next   = upd_iplen;
                ts_next      = upd_ts;
                sport_next   = upd_sport;
                dport_next   = upd_dport;
                l4len_next   = upd_l4len;
                type_hi_next = upd_type_hi;
            end
        end
    end

    // classify
    assign tcp_ok = (fin_reg.ether_class != ETH_OTHER) && (fin_reg.last_pos != POS_SAT)
                    && (fin_reg.l4_protocol == PROTO_TCP)
                    && (fin_reg.last_pos >= ({9'd0, fin_reg.transport_start} + OFF_TCP_DOFF));
    assign udp_ok = (fin_reg.ether_class != ETH_OTHER) && (fin_reg.last_pos != POS_SAT)
                    && (fin_reg.l4_protocol == PROTO_UDP)
                    && (fin_reg.last_pos >= ({9'd0, fin_reg.transport_start} + OFF_LEN_LO));
    assign ihb_eff  = (fin_reg.ether_class == ETH_IPV4) ? fin_reg.ip_header_bytes : 6'd0;
    assign v_tcp    = {2'b00, fin_reg.ip_length} - {12'd0, ihb_eff}
                      - {12'd0, fin_reg.l4_len[5:0]};
    assign v_udp    = {2'b00, fin_reg.l4_len} - {12'd0, UDP_HDR_BYTES};
    assign v_sel    = tcp_ok ? v_tcp : v_udp;
    assign pl_clamp = v_sel[17] ? 16'd0 : v_sel[15:0];

    always_comb begin
        res_calc = '0;
        if (tcp_ok || udp_ok) begin
            res_calc.kind        = tcp_ok ? KIND_TCP : KIND_UDP;
            res_calc.source_port = fin_reg.source_port;
            res_calc.dest_port   = fin_reg.dest_port;
            res_calc.payload_len = pl_clamp;
            res_calc.matched     = (filter_reg == 16'd0) || (fin_reg.source_port == filter_reg)
                                   || (fin_reg.dest_port == filter_reg);
            if (tcp_ok) begin
                res_calc.l4_header_len = fin_reg.l4_len[5:0];
                res_calc.byte_inc      = {11'd0, fin_reg.l4_len[5:0]} + {1'b0, pl_clamp};
            end else begin
                res_calc.l4_header_len = UDP_HDR_BYTES;
                res_calc.byte_inc      = {1'b0, fin_reg.l4_len};
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            class_reg      <= ETH_OTHER;
            ihb_reg        <= '0;
            proto_reg      <= '0;
            iplen_reg      <= '0;
            ts_reg         <= '0;
            sport_reg      <= '0;
            dport_reg      <= '0;
            l4len_reg      <= '0;
            type_hi_reg    <= '0;
            filter_reg     <= '0;
            fin_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            tot_cnt_reg    <= '0;
            tcp_cnt_reg    <= '0;
            udp_cnt_reg    <= '0;
            tcpm_cnt_reg   <= '0;
            udpm_cnt_reg   <= '0;
            tcp_octets_reg <= '0;
            udp_octets_reg <= '0;
        end else begin
            pos_reg       <= pos_next;
            class_reg     <= class_next;
            ihb_reg       <= ihb_next;
            proto_reg     <= proto_next;
            iplen_reg     <= iplen_next;
            ts_reg        <= ts_next;
            sport_reg     <= sport_next;
            dport_reg     <= dport_next;
            l4len_reg     <= l4len_next;
            type_hi_reg   <= type_hi_next;
            fin_valid_reg <= fin_valid_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                filter_reg <= cfg_wr_data;
            end
            if (res_adv) begin
                tot_cnt_reg <= tot_cnt_reg + COUNT_WIDTH'(1);
                if (res_reg.kind == KIND_TCP) begin
                    tcp_cnt_reg    <= tcp_cnt_reg + COUNT_WIDTH'(1);
                    tcp_octets_reg <= tcp_octets_reg + BYTE_COUNT_WIDTH'(res_reg.byte_inc);
                    if (res_reg.matched) begin
                        tcpm_cnt_reg <= tcpm_cnt_reg + COUNT_WIDTH'(1);
                    end
                end
                if (res_reg.kind == KIND_UDP) begin
                    udp_cnt_reg    <= udp_cnt_reg + COUNT_WIDTH'(1);
                    udp_octets_reg <= udp_octets_reg + BYTE_COUNT_WIDTH'(res_reg.byte_inc);
                    if (res_reg.matched) begin
                        udpm_cnt_reg <= udpm_cnt_reg + COUNT_WIDTH'(1);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer && s_data.frame_end) begin
            fin_reg.ether_class     <= upd_class;
            fin_reg.l4_protocol     <= upd_proto;
            fin_reg.ip_length       <= upd_iplen;
            fin_reg.ip_header_bytes <= upd_ihb;
            fin_reg.transport_start <= upd_ts;
            fin_reg.source_port     <= upd_sport;
            fin_reg.dest_port       <= upd_dport;
            fin_reg.l4_len          <= upd_l4len;
            fin_reg.last_pos        <= pos_reg;
        end
        if (fin_adv) begin
            res_reg <= res_calc;
        end
        if (res_adv) begin
            out_reg <= res_reg;
        end
    end

    // result port, counters already hold the values after this frame
    assign m_valid = out_valid_reg;

    always_comb begin
        m_data               = '0;
        m_data.kind          = out_reg.kind;
        m_data.source_port   = out_reg.source_port;
        m_data.dest_port     = out_reg.dest_port;
        m_data.l4_header_len = out_reg.l4_header_len;
        m_data.payload_len   = out_reg.payload_len;
        m_data.matched       = out_reg.matched;
        m_data.frame_count   = 32'(tot_cnt_reg);
        m_data.tcp_count     = 32'(tcp_cnt_reg);
        m_data.udp_count     = 32'(udp_cnt_reg);
        m_data.tcp_matched   = 32'(tcpm_cnt_reg);
        m_data.udp_matched   = 32'(udpm_cnt_reg);
        case (out_reg.kind)
            KIND_TCP: m_data.class_bytes = 48'(tcp_octets_reg);
            KIND_UDP: m_data.class_bytes = 48'(udp_octets_reg);
            default:  m_data.class_bytes = 48'd0;
        endcase
    end

`ifndef SYNTH
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.frame_end |=> pos_reg == 16'd0 && class_reg == ETH_OTHER)
        else $error("per-frame state not cleared after last byte");

    a_other_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_OTHER |-> m_data.source_port == 16'd0
            && m_data.dest_port == 16'd0 && m_data.l4_header_len == 6'd0
            && m_data.payload_len == 16'd0 && !m_data.matched && m_data.class_bytes == 48'd0)
        else $error("unclassified frame carries transport fields");

    a_udp_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_UDP |-> m_data.l4_header_len == UDP_HDR_BYTES)
        else $error("udp result with wrong header length");

    a_res_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        res_adv |=> m_valid)
        else $error("classified frame lost before result register");
`endif

endmodule
